>>> src/esc_pkg.sv
// Package for the exponential soft clipper: configuration types, register codes
// and the elaboration-time functions that build the 1-exp(-t) table.
// No dependencies.
package esc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam logic [CFG_W-1:0] GAIN_RST  = 16'd4096;
  localparam logic [CFG_W-1:0] BLEND_RST = 16'd32768;

  typedef enum logic {
    REG_GAIN  = 1'b0,
    REG_BLEND = 1'b1
  } esc_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] blend;
  } esc_cfg_t;

  // exp(-h) in Q31 from a Taylor series truncated after the h^24 term, h given in Q31.
  function automatic logic [63:0] exp_factor(input logic [63:0] h);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 31;
    pos  = term;
    neg  = 64'd0;
    term = ((term * h) >> 31) / 64'd1;  neg = neg + term;
    term = ((term * h) >> 31) / 64'd2;  pos = pos + term;
    term = ((term * h) >> 31) / 64'd3;  neg = neg + term;
    term = ((term * h) >> 31) / 64'd4;  pos = pos + term;
    term = ((term * h) >> 31) / 64'd5;  neg = neg + term;
    term = ((term * h) >> 31) / 64'd6;  pos = pos + term;
    term = ((term * h) >> 31) / 64'd7;  neg = neg + term;
    term = ((term * h) >> 31) / 64'd8;  pos = pos + term;
    term = ((term * h) >> 31) / 64'd9;  neg = neg + term;
    term = ((term * h) >> 31) / 64'd10; pos = pos + term;
    term = ((term * h) >> 31) / 64'd11; neg = neg + term;
    term = ((term * h) >> 31) / 64'd12; pos = pos + term;
    term = ((term * h) >> 31) / 64'd13; neg = neg + term;
    term = ((term * h) >> 31) / 64'd14; pos = pos + term;
    term = ((term * h) >> 31) / 64'd15; neg = neg + term;
    term = ((term * h) >> 31) / 64'd16; pos = pos + term;
    term = ((term * h) >> 31) / 64'd17; neg = neg + term;
    term = ((term * h) >> 31) / 64'd18; pos = pos + term;
    term = ((term * h) >> 31) / 64'd19; neg = neg + term;
    term = ((term * h) >> 31) / 64'd20; pos = pos + term;
    term = ((term * h) >> 31) / 64'd21; neg = neg + term;
    term = ((term * h) >> 31) / 64'd22; pos = pos + term;
    term = ((term * h) >> 31) / 64'd23; neg = neg + term;
    term = ((term * h) >> 31) / 64'd24; pos = pos + term;
    return pos - neg;
  endfunction

  // Table entry k: 1 - r^k in Q31, with r^k built by repeated rounded products.
  function automatic logic [31:0] rom_entry(input int unsigned k, input logic [63:0] r);
    logic [63:0] e;
    e = 64'd1 << 31;
    for (int unsigned i = 0; i < k; i++) begin
      e = (e * r + (64'd1 << 30)) >> 31;
    end
    return 32'((64'd1 << 31) - e);
  endfunction

endpackage

>>> src/esc_in_if.sv
// Input sample channel of the soft clipper: valid/ready handshake plus sample.
// No dependencies.
interface esc_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

>>> src/esc_out_if.sv
// Output sample channel of the soft clipper: valid/ready handshake plus sample.
// No dependencies.
interface esc_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> src/esc_pipe.sv
// Eight-stage datapath of the soft clipper: magnitude, gain product, table
// position, table read, interpolation, blend product, rounding and saturation.
// Depends on esc_pkg.
module esc_pipe #(
  parameter int unsigned SAMPLE_BITS   = esc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TABLE_ENTRIES = esc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esc_pkg::esc_cfg_t      cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned NSTG = 8;
  localparam int unsigned IW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TW   = 16 + S;
  localparam int unsigned PW   = TW + IW;
  localparam int unsigned XW   = PW - S - 15;
  localparam logic [63:0] StepH  = (64'd1 << 35) / TABLE_ENTRIES;
  localparam logic [63:0] RatioR = esc_pkg::exp_factor(StepH);

  logic en;

  // Constant table of 1-exp(-t), t = 0 .. 16, folded to logic by synthesis.
  logic [31:0] rom_w [TABLE_ENTRIES+1];
  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
    assign rom_w[k] = esc_pkg::rom_entry(k, RatioR);
  end

  // Side data that travels with every sample.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] neg_q;
  logic [NSTG-1:0] byp_q;
  logic [S-1:0]    smp_q [NSTG];

  logic [S-1:0]    a0_d, a0_q;
  logic [TW-1:0]   t1_d, t1_q;
  logic [PW-1:0]   p2;
  logic [XW-1:0]   idx2_full;
  logic [IW-1:0]   idx2_d, idx2_q;
  logic [15:0]     frac2_q, frac3_q;
  logic [IW-1:0]   idx_hi;
  logic [31:0]     lo3_q, lo4_q, diff3_d, diff3_q;
  logic [47:0]     prod4_d, prod4_q;
  logic [48:0]     rnd5;
  logic [31:0]     v5_d, v5_q;
  logic [47:0]     y6_d, y6_q;
  logic [48:0]     rnd7;
  logic [S+1:0]    mag7, lim7, sat7;
  logic [S-1:0]    out_d;

  // The whole pipe freezes while a finished sample waits at the output.
  assign en          = !(vld_q[NSTG-1] && !out_ready_i);
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NSTG-1];
  assign sample_out_o = smp_q[NSTG-1];

  assign a0_d = sample_in_i[S-1] ? S'(~sample_in_i + 1'b1) : sample_in_i;
  assign t1_d = TW'(cfg_i.gain) * TW'(a0_q);

  always_comb begin
    p2        = PW'(t1_q) * PW'(TABLE_ENTRIES);
    idx2_full = p2[PW-1:S+15];
    if (idx2_full > XW'(TABLE_ENTRIES - 1)) begin
      idx2_d = IW'(TABLE_ENTRIES - 1);
    end else begin
      idx2_d = idx2_full[IW-1:0];
    end
  end

  assign idx_hi  = idx2_q + 1'b1;
  assign diff3_d = rom_w[idx_hi] - rom_w[idx2_q];
  assign prod4_d = 48'(diff3_q) * 48'(frac3_q);
  assign rnd5    = {1'b0, prod4_q} + 49'h8000;
  assign v5_d    = lo4_q + rnd5[47:16];
  assign y6_d    = 48'(cfg_i.blend) * 48'(v5_q);

  always_comb begin
    rnd7 = {1'b0, y6_q} + (49'd1 << (46 - S));
    mag7 = rnd7[48:47-S];
    lim7 = neg_q[NSTG-2] ? ((S+2)'(1) << (S - 1)) : (((S+2)'(1) << (S - 1)) - 1'b1);
    sat7 = (mag7 > lim7) ? lim7 : mag7;
    if (byp_q[NSTG-2]) begin
      out_d = smp_q[NSTG-2];
    end else if (neg_q[NSTG-2]) begin
      out_d = S'(~sat7 + 1'b1);
    end else begin
      out_d = sat7[S-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      smp_q[0] <= sample_in_i;
      neg_q[0] <= sample_in_i[S-1];
      byp_q[0] <= (cfg_i.gain == '0) || (cfg_i.blend == '0);
      for (int i = 1; i < NSTG - 1; i++) begin
        smp_q[i] <= smp_q[i-1];
        neg_q[i] <= neg_q[i-1];
        byp_q[i] <= byp_q[i-1];
      end
      smp_q[NSTG-1] <= out_d;
      neg_q[NSTG-1] <= neg_q[NSTG-2];
      byp_q[NSTG-1] <= byp_q[NSTG-2];
      a0_q    <= a0_d;
      t1_q    <= t1_d;
      idx2_q  <= idx2_d;
      frac2_q <= p2[S+14:S-1];
      lo3_q   <= rom_w[idx2_q];
      diff3_q <= diff3_d;
      frac3_q <= frac2_q;
      prod4_q <= prod4_d;
      lo4_q   <= lo3_q;
      v5_q    <= v5_d;
      y6_q    <= y6_d;
    end
  end

  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[NSTG-2] |=> vld_q[NSTG-1])
    else $error("sample lost between the last two stages");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> idx2_q <= IW'(TABLE_ENTRIES - 1))
    else $error("table index beyond the last segment");

  a_sign_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-1] && !byp_q[NSTG-1] && !neg_q[NSTG-1] |-> !smp_q[NSTG-1][S-1])
    else $error("positive sample came out negative");

  a_interp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> v5_q <= 32'h8000_0000)
    else $error("interpolated curve value above one");

endmodule

>>> src/exponential_soft_clip.sv
// Top level of the exponential soft clipper: APB register file and the
// datapath pipeline. Depends on esc_pkg, esc_in_if, esc_out_if and esc_pipe.
//
//   channel   kind       direction  carries
//   in_i      valid/rdy  in         sample_in, signed Q1.(SAMPLE_BITS-1)
//   out_o     valid/rdy  out        sample_out, signed Q1.(SAMPLE_BITS-1)
//   APB       psel/pen   in/out     gain at 0x0, blend at 0x4
//
// One sample enters every cycle while in_i.ready is high; a result is offered
// on out_o once its input has passed the eight register stages of esc_pipe.
// Reset clears the valid bits and loads gain = 1.0 and blend = 1.0.
// While a result waits at the output the whole pipe holds and in_i.ready is low.
// Register writes are meant for times when the pipe is empty.
module exponential_soft_clip #(
  parameter int unsigned SAMPLE_BITS   = esc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TABLE_ENTRIES = esc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  esc_in_if.sink                       in_i,
  esc_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esc_pkg::ADDR_W-1:0]   paddr,
  input  logic [esc_pkg::DATA_W-1:0]   pwdata,
  output logic [esc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  esc_pkg::esc_cfg_t cfg_q;
  esc_pkg::esc_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = esc_pkg::esc_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain  <= esc_pkg::GAIN_RST;
      cfg_q.blend <= esc_pkg::BLEND_RST;
    end else if (wr_en) begin
      case (reg_sel)
        esc_pkg::REG_GAIN:  cfg_q.gain  <= pwdata[esc_pkg::CFG_W-1:0];
        esc_pkg::REG_BLEND: cfg_q.blend <= pwdata[esc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      esc_pkg::REG_GAIN:  prdata = esc_pkg::DATA_W'(cfg_q.gain);
      esc_pkg::REG_BLEND: prdata = esc_pkg::DATA_W'(cfg_q.blend);
      default:            prdata = '0;
    endcase
  end

  esc_pipe #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .sample_in_i  (in_i.sample_in),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .sample_out_o (out_o.sample_out)
  );

endmodule

>>> sim/exponential_soft_clip_test.sv
`timescale 1ns / 100ps
// Testbench for exponential_soft_clip: drives samples and APB register writes,
// checks every output sample against the probe table or a bit-exact curve predictor.
// Depends on esc_pkg, esc_in_if, esc_out_if and the exponential_soft_clip RTL.
module exponential_soft_clip_test;

  localparam int unsigned SW          = esc_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned TABLE_N     = esc_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned PIPE_DEPTH  = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_PROBES    = 22;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 135;

  typedef struct packed {
    logic [esc_pkg::CFG_W-1:0] gain;
    logic [esc_pkg::CFG_W-1:0] blend;
    logic [SW-1:0]             sample;
    logic                      typed;
    logic [SW-1:0]             result;
  } probe_t;

  // Rows with typed = 1 carry a result that follows directly from the curve's
  // definition; the others are checked against the predictor.
  localparam probe_t PROBES [0:N_PROBES-1] = '{
    '{16'd4096,  16'd32768, 16'h0000, 1'b1, 16'h0000},
    '{16'd4096,  16'd32768, 16'h7fff, 1'b0, 16'h0000},
    '{16'd4096,  16'd32768, 16'h8000, 1'b0, 16'h0000},
    '{16'd4096,  16'd32768, 16'h0001, 1'b0, 16'h0000},
    '{16'd4096,  16'd32768, 16'hffff, 1'b0, 16'h0000},
    '{16'd0,     16'd32768, 16'h1234, 1'b1, 16'h1234},
    '{16'd0,     16'd32768, 16'h8000, 1'b1, 16'h8000},
    '{16'd0,     16'd32768, 16'h7fff, 1'b1, 16'h7fff},
    '{16'd4096,  16'd0,     16'habcd, 1'b1, 16'habcd},
    '{16'd4096,  16'd0,     16'h0000, 1'b1, 16'h0000},
    '{16'd40960, 16'd65535, 16'h7fff, 1'b1, 16'h7fff},
    '{16'd40960, 16'd65535, 16'h8000, 1'b1, 16'h8000},
    '{16'd40960, 16'd65535, 16'h4000, 1'b1, 16'h7fff},
    '{16'd40960, 16'd65535, 16'hc000, 1'b1, 16'h8000},
    '{16'd65535, 16'd32768, 16'h7fff, 1'b0, 16'h0000},
    '{16'd65535, 16'd32768, 16'h8000, 1'b0, 16'h0000},
    '{16'd65535, 16'd32768, 16'h0001, 1'b0, 16'h0000},
    '{16'd1,     16'd1,     16'h7fff, 1'b0, 16'h0000},
    '{16'd1,     16'd1,     16'h0000, 1'b1, 16'h0000},
    '{16'd40960, 16'd32768, 16'h8000, 1'b0, 16'h0000},
    '{16'd40960, 16'd32768, 16'h0000, 1'b1, 16'h0000},
    '{16'd40960, 16'd32768, 16'h00ff, 1'b0, 16'h0000}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [esc_pkg::ADDR_W-1:0] paddr;
  logic [esc_pkg::DATA_W-1:0] pwdata;
  logic [esc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  esc_in_if  #(.SAMPLE_BITS(SW)) in_ch ();
  esc_out_if #(.SAMPLE_BITS(SW)) out_ch ();

  exponential_soft_clip #(
    .SAMPLE_BITS  (SW),
    .TABLE_ENTRIES(TABLE_N)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [63:0]               curve_rom [0:TABLE_N];
  logic [esc_pkg::CFG_W-1:0] gain_setting;
  logic [esc_pkg::CFG_W-1:0] blend_setting;
  logic [SW-1:0]             clipped_q [$];
  int unsigned               mismatch_count = 0;
  int unsigned               cycle_count = 0;
  int unsigned               send_idle_pct = 0;
  int unsigned               stall_pct = 0;

  always #5 clk_i = ~clk_i;

  // Samples of 1 - exp(-t) in Q31 over t = 0 .. 16, built from the same
  // truncated series and rounded products as the hardware table.
  function automatic void build_curve();
    logic [63:0] step_q31;
    logic [63:0] term;
    logic [63:0] sum_even;
    logic [63:0] sum_odd;
    logic [63:0] ratio;
    logic [63:0] decay;
    step_q31 = (64'd1 << 35) / 64'(TABLE_N);
    term     = 64'd1 << 31;
    sum_even = term;
    sum_odd  = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * step_q31) >> 31) / 64'(k);
      if (k % 2 == 1) sum_odd = sum_odd + term;
      else sum_even = sum_even + term;
    end
    ratio = sum_even - sum_odd;
    decay = 64'd1 << 31;
    for (int k = 0; k <= TABLE_N; k++) begin
      curve_rom[k] = (64'd1 << 31) - decay;
      decay = (decay * ratio + (64'd1 << 30)) >> 31;
    end
  endfunction

  function automatic logic [SW-1:0] clip_sample(input logic [SW-1:0] x);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] interp;
    logic [63:0] scaled;
    logic [63:0] limit;
    if (gain_setting == '0 || blend_setting == '0) return x;
    neg  = x[SW-1];
    mag  = neg ? ((64'd1 << SW) - 64'(x)) : 64'(x);
    pos  = 64'(gain_setting) * mag * 64'(TABLE_N);
    idx  = pos >> (SW + 15);
    if (idx >= 64'(TABLE_N)) idx = 64'(TABLE_N - 1);
    frac = (pos >> (SW - 1)) & 64'hffff;
    interp = curve_rom[idx] +
             (((curve_rom[idx + 1] - curve_rom[idx]) * frac + 64'h8000) >> 16);
    scaled = (64'(blend_setting) * interp + (64'd1 << (46 - SW))) >> (47 - SW);
    limit  = neg ? (64'd1 << (SW - 1)) : ((64'd1 << (SW - 1)) - 64'd1);
    if (scaled > limit) scaled = limit;
    return neg ? SW'(64'd0 - scaled) : SW'(scaled);
  endfunction

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // One register write followed by a read-back; leaves the bus idle.
  task automatic write_reg(input esc_pkg::esc_reg_e which,
                           input logic [esc_pkg::CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= esc_pkg::DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (which == esc_pkg::REG_GAIN) gain_setting = value;
    else blend_setting = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[esc_pkg::CFG_W-1:0] !== value)
      note_mismatch($sformatf("register %s reads %h, wrote %h", which.name(),
                              prdata[esc_pkg::CFG_W-1:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one sample, with random idle cycles in front, and records what
  // should come back once the transaction completes.
  task automatic push_sample(input logic [SW-1:0] x, input logic typed,
                             input logic [SW-1:0] result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    clipped_q.insert(clipped_q.size(), typed ? result : clip_sample(x));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  function automatic logic [esc_pkg::CFG_W-1:0] pick_setting(
      input logic [esc_pkg::CFG_W-1:0] top);
    case ($urandom_range(9))
      0:       return '0;
      1:       return top;
      2:       return 16'hffff;
      3:       return 16'd1;
      default: return esc_pkg::CFG_W'($urandom_range(1, int'(top)));
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(3))
      0: return SW'($urandom_range(255));
      1: return SW'(0 - $urandom_range(256));
      2: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return SW'(1);
          2:       return '1;
          3:       return {1'b0, {(SW-1){1'b1}}};
          default: return {1'b1, {(SW-1){1'b0}}};
        endcase
      end
      default: return SW'($urandom());
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (clipped_q.size() == 0) begin
        note_mismatch($sformatf("unexpected output sample %h", out_ch.sample_out));
      end else begin
        if (out_ch.sample_out !== clipped_q[0])
          note_mismatch($sformatf("sample_out %h, expected %h",
                                  out_ch.sample_out, clipped_q[0]));
        void'(clipped_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    gain_setting    = esc_pkg::GAIN_RST;
    blend_setting   = esc_pkg::BLEND_RST;
    build_curve();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PROBES[i]) begin
      if (PROBES[i].gain != gain_setting || PROBES[i].blend != blend_setting) begin
        wait_drained();
        write_reg(esc_pkg::REG_GAIN, PROBES[i].gain);
        write_reg(esc_pkg::REG_BLEND, PROBES[i].blend);
      end
      push_sample(PROBES[i].sample, PROBES[i].typed, PROBES[i].result);
    end

    // Each phase gets a fresh register setting and one of four idling patterns, by phase % 4.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if (phase == 0) begin
        write_reg(esc_pkg::REG_GAIN, 16'd40960);
        write_reg(esc_pkg::REG_BLEND, 16'd32768);
      end else begin
        write_reg(esc_pkg::REG_GAIN, pick_setting(16'd40960));
        write_reg(esc_pkg::REG_BLEND, pick_setting(16'd32768));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) push_sample(pick_sample(), 1'b0, '0);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/esc_pkg.sv
src/esc_in_if.sv
src/esc_out_if.sv
src/esc_pipe.sv
src/exponential_soft_clip.sv
sim/exponential_soft_clip_test.sv
